// File: rtl/core/euler_2d_flux_kernel_defines.svh
// Assertion macros for the checker file.
`ifndef EULER_2D_FLUX_KERNEL_DEFINES_SVH
`define EULER_2D_FLUX_KERNEL_DEFINES_SVH

// Same-cycle implication, off during reset.
`define E2F_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("e2f assertion failed");

// Next-cycle implication, off during reset.
`define E2F_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("e2f assertion failed");

// Next-cycle implication that also holds across reset.
`define E2F_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("e2f assertion failed");

`endif

// File: rtl/core/e2f_pkg.sv
package e2f_pkg;

    localparam int DW            = 32;
    localparam int SW            = 128;
    localparam int FRAC_BITS_DEF = 16;
    localparam int GAMMA_W       = 18;

    localparam logic [GAMMA_W-1:0] GAMMA_RST = 18'd91750;

    localparam logic signed [SW-1:0] SAT_HI = 128'sd2147483647;
    localparam logic signed [SW-1:0] SAT_LO = -128'sd2147483648;

    typedef logic signed [DW-1:0] data_t;

    function automatic data_t sat32(input logic signed [SW-1:0] x);
        if (x > SAT_HI) begin
            return data_t'(SAT_HI[DW-1:0]);
        end else if (x < SAT_LO) begin
            return data_t'(SAT_LO[DW-1:0]);
        end
        return data_t'(x[DW-1:0]);
    endfunction

endpackage

// File: rtl/core/e2f_div.sv
module e2f_div
    import e2f_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  logic signed [DW-1:0] num,
    input  logic [DW-1:0]     den,
    output logic signed [DW-1:0] quo
);

    localparam int NW = DW + FRAC_BITS;
    localparam int RW = DW + 1;
    localparam int AW = RW + NW;

    // acc holds remainder above, numerator bits shifting out and quotient bits shifting in
    logic [AW-1:0] acc_reg [NW+1];
    logic [DW-1:0] den_reg [NW+1];
    logic          neg_reg [NW+1];
    logic signed [DW-1:0] quo_reg;

    logic [DW-1:0] mag_next;
    assign mag_next = num[DW-1] ? (DW'(~num) + DW'(1)) : DW'(num);

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg[0] <= {RW'(0), mag_next, FRAC_BITS'(0)};
            den_reg[0] <= den;
            neg_reg[0] <= num[DW-1];
        end
    end

    for (genvar i = 0; i < NW; i++) begin : g_step
        logic [AW-1:0] step_next;
        logic [RW-1:0] top_v;
        always_comb begin
            step_next = acc_reg[i] << 1;
            top_v     = step_next[AW-1:NW];
            if (top_v >= RW'(den_reg[i])) begin
                step_next[AW-1:NW] = top_v - RW'(den_reg[i]);
                step_next[0]       = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[i+1] <= step_next;
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    logic [NW-1:0] q_mag;
    logic          q_hi;
    logic [DW-1:0] q_lo;
    logic signed [DW-1:0] quo_next;

    assign q_mag = acc_reg[NW][NW-1:0];
    assign q_hi  = |q_mag[NW-1:DW];
    assign q_lo  = q_mag[DW-1:0];

    always_comb begin
        if (!neg_reg[NW]) begin
            if (q_hi || q_lo[DW-1]) begin
                quo_next = data_t'(SAT_HI[DW-1:0]);
            end else begin
                quo_next = data_t'(q_lo);
            end
        end else begin
            if (q_hi || (q_lo > {1'b1, {(DW-1){1'b0}}})) begin
                quo_next = data_t'(SAT_LO[DW-1:0]);
            end else begin
                quo_next = data_t'(~q_lo + DW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// File: rtl/core/euler_2d_flux_kernel.sv
// Ideal-gas 2D Euler flux kernel. One cell state (density, momenta, energy) in,
// velocities, pressure and both flux vectors out, signed fixed point with
// FRAC_BITS fraction bits (Q16.16 by default), saturated. A new item is taken
// every clock while the output is not stalled; the pipeline is two restoring
// dividers (one quotient bit per stage) plus nine multiply and saturate stages.
// The whole pipeline holds while the output register is full and not taken.
// gamma_ratio is written on the cfg port and should be changed only when idle.
module euler_2d_flux_kernel
    import e2f_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [GAMMA_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_density,
    input  logic signed [31:0] s_mom_x,
    input  logic signed [31:0] s_mom_y,
    input  logic signed [31:0] s_total_energy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_vel_u,
    output logic signed [31:0] m_vel_v,
    output logic signed [31:0] m_pressure,
    output logic signed [31:0] m_fx_mass,
    output logic signed [31:0] m_fx_momx,
    output logic signed [31:0] m_fx_momy,
    output logic signed [31:0] m_fx_energy,
    output logic signed [31:0] m_gy_mass,
    output logic signed [31:0] m_gy_momx,
    output logic signed [31:0] m_gy_momy,
    output logic signed [31:0] m_gy_energy,
    output logic               m_bad_density
);

    localparam int LAT_DIV = DW + FRAC_BITS + 2;
    localparam int GW      = (FRAC_BITS + 2 > GAMMA_W + 1) ? FRAC_BITS + 2 : GAMMA_W + 1;
    localparam logic signed [GW-1:0] ONE_Q = GW'(64'sd1 <<< FRAC_BITS);

    typedef struct packed {
        data_t rho;
        data_t mx;
        data_t my;
        data_t en;
        data_t u;
        data_t v;
        logic  bad;
    } cell_t;

    logic [GAMMA_W-1:0] gamma_reg;
    logic               en;
    logic               out_vld_reg;

    assign cfg_ready = 1'b1;
    assign en        = !out_vld_reg || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= GAMMA_RST;
        end else if (cfg_valid) begin
            gamma_reg <= cfg_data;
        end
    end

    // divider lanes and sideband delay line
    data_t u_q, v_q;

    e2f_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
        .aclk(aclk), .en(en), .num(s_mom_x), .den(DW'(s_density)), .quo(u_q)
    );
    e2f_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
        .aclk(aclk), .en(en), .num(s_mom_y), .den(DW'(s_density)), .quo(v_q)
    );

    cell_t dl_reg  [LAT_DIV];
    logic  dvld_reg[LAT_DIV];
    cell_t cell_next;

    always_comb begin
        cell_next     = '0;
        cell_next.rho = s_density;
        cell_next.mx  = s_mom_x;
        cell_next.my  = s_mom_y;
        cell_next.en  = s_total_energy;
        cell_next.bad = (s_density <= 0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg[0] <= cell_next;
            for (int i = 1; i < LAT_DIV; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT_DIV; i++) begin
                dvld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            dvld_reg[0] <= s_valid;
            for (int i = 1; i < LAT_DIV; i++) begin
                dvld_reg[i] <= dvld_reg[i-1];
            end
        end
    end

    cell_t s0_next;
    always_comb begin
        s0_next   = dl_reg[LAT_DIV-1];
        s0_next.u = u_q;
        s0_next.v = v_q;
    end

    // arithmetic stages
    cell_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg, c8_reg;
    logic  [8:1] vld_reg;

    logic signed [63:0] uu1_reg, vv1_reg, ru1_reg, rv1_reg;
    logic signed [32:0] sq2_reg;
    data_t              ru2_reg, rv2_reg;
    logic signed [64:0] ke3_reg;
    logic signed [63:0] ruu3_reg, ruv3_reg, rvv3_reg;
    logic signed [32:0] dif4_reg;
    data_t              ruu4_reg, ruv4_reg, rvv4_reg;
    logic signed [32+GW:0] pp5_reg;
    data_t              ruu5_reg, ruv5_reg, rvv5_reg;
    data_t              p6_reg, ruu6_reg, ruv6_reg, rvv6_reg;
    logic signed [32:0] ep7_reg;
    data_t              p7_reg, fxm7_reg, gym7_reg, ruv7_reg;
    logic signed [64:0] ue8_reg, ve8_reg;
    data_t              p8_reg, fxm8_reg, gym8_reg, ruv8_reg;

    logic signed [32:0] sq_next, dif_next, ep_next;
    logic signed [GW-1:0] g1_next;
    data_t ke_next;

    assign sq_next  = 33'(sat32(SW'(uu1_reg >>> FRAC_BITS)))
                    + 33'(sat32(SW'(vv1_reg >>> FRAC_BITS)));
    assign ke_next  = sat32(SW'(ke3_reg >>> (FRAC_BITS + 1)));
    assign dif_next = 33'(c3_reg.en) - 33'(ke_next);
    assign g1_next  = $signed(GW'(gamma_reg)) - ONE_Q;
    assign ep_next  = 33'(c6_reg.en) + 33'(p6_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg  <= s0_next;
            uu1_reg <= s0_next.u * s0_next.u;
            vv1_reg <= s0_next.v * s0_next.v;
            ru1_reg <= s0_next.rho * s0_next.u;
            rv1_reg <= s0_next.rho * s0_next.v;

            c2_reg  <= c1_reg;
            sq2_reg <= sq_next;
            ru2_reg <= sat32(SW'(ru1_reg >>> FRAC_BITS));
            rv2_reg <= sat32(SW'(rv1_reg >>> FRAC_BITS));

            c3_reg   <= c2_reg;
            ke3_reg  <= c2_reg.rho * sq2_reg;
            ruu3_reg <= ru2_reg * c2_reg.u;
            ruv3_reg <= ru2_reg * c2_reg.v;
            rvv3_reg <= rv2_reg * c2_reg.v;

            c4_reg   <= c3_reg;
            dif4_reg <= dif_next;
            ruu4_reg <= sat32(SW'(ruu3_reg >>> FRAC_BITS));
            ruv4_reg <= sat32(SW'(ruv3_reg >>> FRAC_BITS));
            rvv4_reg <= sat32(SW'(rvv3_reg >>> FRAC_BITS));

            c5_reg   <= c4_reg;
            pp5_reg  <= dif4_reg * g1_next;
            ruu5_reg <= ruu4_reg;
            ruv5_reg <= ruv4_reg;
            rvv5_reg <= rvv4_reg;

            c6_reg   <= c5_reg;
            p6_reg   <= sat32(SW'(pp5_reg >>> FRAC_BITS));
            ruu6_reg <= ruu5_reg;
            ruv6_reg <= ruv5_reg;
            rvv6_reg <= rvv5_reg;

            c7_reg   <= c6_reg;
            ep7_reg  <= ep_next;
            p7_reg   <= p6_reg;
            fxm7_reg <= sat32(SW'(ruu6_reg) + SW'(p6_reg));
            gym7_reg <= sat32(SW'(rvv6_reg) + SW'(p6_reg));
            ruv7_reg <= ruv6_reg;

            c8_reg   <= c7_reg;
            ue8_reg  <= c7_reg.u * ep7_reg;
            ve8_reg  <= c7_reg.v * ep7_reg;
            p8_reg   <= p7_reg;
            fxm8_reg <= fxm7_reg;
            gym8_reg <= gym7_reg;
            ruv8_reg <= ruv7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[7:1], dvld_reg[LAT_DIV-1]};
            out_vld_reg <= vld_reg[8];
        end
    end

    // output register; a bad density zeroes every field
    data_t o_u_reg, o_v_reg, o_p_reg, o_fxa_reg, o_fxm_reg, o_fxy_reg, o_fxe_reg;
    data_t o_gya_reg, o_gym_reg, o_gye_reg;
    logic  o_bad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            o_bad_reg <= c8_reg.bad;
            if (c8_reg.bad) begin
                o_u_reg   <= '0;
                o_v_reg   <= '0;
                o_p_reg   <= '0;
                o_fxa_reg <= '0;
                o_fxm_reg <= '0;
                o_fxy_reg <= '0;
                o_fxe_reg <= '0;
                o_gya_reg <= '0;
                o_gym_reg <= '0;
                o_gye_reg <= '0;
            end else begin
                o_u_reg   <= c8_reg.u;
                o_v_reg   <= c8_reg.v;
                o_p_reg   <= p8_reg;
                o_fxa_reg <= c8_reg.mx;
                o_fxm_reg <= fxm8_reg;
                o_fxy_reg <= ruv8_reg;
                o_fxe_reg <= sat32(SW'(ue8_reg >>> FRAC_BITS));
                o_gya_reg <= c8_reg.my;
                o_gym_reg <= gym8_reg;
                o_gye_reg <= sat32(SW'(ve8_reg >>> FRAC_BITS));
            end
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_vel_u       = o_u_reg;
    assign m_vel_v       = o_v_reg;
    assign m_pressure    = o_p_reg;
    assign m_fx_mass     = o_fxa_reg;
    assign m_fx_momx     = o_fxm_reg;
    assign m_fx_momy     = o_fxy_reg;
    assign m_fx_energy   = o_fxe_reg;
    assign m_gy_mass     = o_gya_reg;
    assign m_gy_momx     = o_fxy_reg;
    assign m_gy_momy     = o_gym_reg;
    assign m_gy_energy   = o_gye_reg;
    assign m_bad_density = o_bad_reg;

endmodule

// File: rtl/core/e2f_checker.sv
`include "euler_2d_flux_kernel_defines.svh"

module e2f_checker
    import e2f_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [GAMMA_W-1:0] cfg_data,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [31:0] s_density,
    input logic signed [31:0] s_mom_x,
    input logic signed [31:0] s_mom_y,
    input logic signed [31:0] s_total_energy,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_vel_u,
    input logic signed [31:0] m_vel_v,
    input logic signed [31:0] m_pressure,
    input logic signed [31:0] m_fx_mass,
    input logic signed [31:0] m_fx_momx,
    input logic signed [31:0] m_fx_momy,
    input logic signed [31:0] m_fx_energy,
    input logic signed [31:0] m_gy_mass,
    input logic signed [31:0] m_gy_momx,
    input logic signed [31:0] m_gy_momy,
    input logic signed [31:0] m_gy_energy,
    input logic               m_bad_density
);

    // a waiting result item holds
    `E2F_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_fx_energy) && $stable(m_pressure))

    // bad density clears the fields; checked on velocity, pressure, x mass flux and y energy flux
    `E2F_ASSERT_IMPLY(a_bad_zero, m_valid && m_bad_density, m_vel_u == 0 && m_vel_v == 0 && m_pressure == 0 && m_fx_mass == 0 && m_gy_energy == 0)

    // the cross momentum fluxes are one term
    `E2F_ASSERT_IMPLY(a_cross, m_valid, m_fx_momy == m_gy_momx)

    // reset empties the pipeline
    `E2F_ASSERT_NEXT_ALWAYS(a_rst_empty, !aresetn, !m_valid)

endmodule

bind euler_2d_flux_kernel e2f_checker u_e2f_checker (.*);

// File: tb/euler_2d_flux_kernel_tb.sv
`timescale 1ns / 100ps

module euler_2d_flux_kernel_tb;
    import e2f_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = FB + 43;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] en;
    } cell_t;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] p;
        logic signed [31:0] fxm;
        logic signed [31:0] fxx;
        logic signed [31:0] fxy;
        logic signed [31:0] fxe;
        logic signed [31:0] gym;
        logic signed [31:0] gyx;
        logic signed [31:0] gyy;
        logic signed [31:0] gye;
        logic               bad;
    } flux_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [GAMMA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_density = '0, s_mom_x = '0, s_mom_y = '0, s_total_energy = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    flux_t got;
    logic m_bad_density;

    euler_2d_flux_kernel dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_density(s_density), .s_mom_x(s_mom_x), .s_mom_y(s_mom_y),
        .s_total_energy(s_total_energy),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_vel_u(got.u), .m_vel_v(got.v), .m_pressure(got.p),
        .m_fx_mass(got.fxm), .m_fx_momx(got.fxx), .m_fx_momy(got.fxy),
        .m_fx_energy(got.fxe), .m_gy_mass(got.gym), .m_gy_momx(got.gyx),
        .m_gy_momy(got.gyy), .m_gy_energy(got.gye), .m_bad_density(m_bad_density)
    );
    assign got.bad = m_bad_density;

    always #6 aclk = ~aclk;

    cell_t cell_q[$];
    flux_t flux_q[$];
    logic [GAMMA_W-1:0] gamma_reg = GAMMA_RST;
    int send_idle = 0, recv_stall = 0;
    int hold_off = 0;
    int mismatches = 0, results_seen = 0, cycles = 0;
    int n_bad = 0, n_sat = 0;

    function automatic logic signed [127:0] clamp32(input logic signed [127:0] x);
        if (x > 128'sd2147483647) return 128'sd2147483647;
        if (x < -128'sd2147483648) return -128'sd2147483648;
        return x;
    endfunction

    // floor(a*b / 2^s), then clamp
    function automatic logic signed [127:0] qmul(input logic signed [127:0] a,
                                                 input logic signed [127:0] b, input int s);
        logic signed [127:0] m;
        m = a * b;
        return clamp32(m >>> s);
    endfunction

    function automatic flux_t cell_flux(input cell_t c, input logic [GAMMA_W-1:0] g);
        flux_t f;
        logic signed [127:0] rho, mx, my, en, u, v, sq, ke, g1, p, ru, rv, ep, num;
        f = '0;
        if (c.rho <= 0) begin
            f.bad = 1'b1;
            return f;
        end
        rho = c.rho; mx = c.mx; my = c.my; en = c.en;
        num = mx <<< FB; u = clamp32(num / rho);
        num = my <<< FB; v = clamp32(num / rho);
        sq = qmul(u, u, FB) + qmul(v, v, FB);
        ke = qmul(rho, sq, FB + 1);
        g1 = $signed({110'd0, g}) - (128'sd1 <<< FB);
        p = qmul(en - ke, g1, FB);
        ru = qmul(rho, u, FB);
        rv = qmul(rho, v, FB);
        ep = en + p;
        f.u = u[31:0]; f.v = v[31:0]; f.p = p[31:0];
        f.fxm = c.mx; f.gym = c.my;
        num = clamp32(qmul(ru, u, FB) + p); f.fxx = num[31:0];
        num = qmul(ru, v, FB); f.fxy = num[31:0];
        f.gyx = f.fxy;
        num = qmul(u, ep, FB); f.fxe = num[31:0];
        num = clamp32(qmul(rv, v, FB) + p); f.gyy = num[31:0];
        num = qmul(v, ep, FB); f.gye = num[31:0];
        return f;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (cell_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                cell_t c;
                c = cell_q.pop_front();
                s_valid <= 1'b1;
                s_density <= c.rho; s_mom_x <= c.mx;
                s_mom_y <= c.my; s_total_energy <= c.en;
                flux_q.push_back(cell_flux(c, gamma_reg));
                if (c.rho <= 0) n_bad++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with its own long hold-off count
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (flux_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
                flux_t e;
                e = flux_q.pop_front();
                if (e.p == 32'sh7fffffff || e.p == 32'sh80000000) n_sat++;
                if (e !== got) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, got);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("euler_2d_flux_kernel regression: fail");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word(input int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(65536 * 4)) - 32'sd131072;
            2: return 32'sh7fffffff;
            3: return 32'sh80000000;
            default: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
        endcase
    endfunction

    function automatic cell_t rand_cell();
        cell_t c;
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            // physical-looking cell
            c.rho = $urandom_range(32'h0400_0000, 32'h0000_1000);
            c.mx = rand_word(4);
            c.my = rand_word(4);
            c.en = $signed($urandom_range(32'h0200_0000));
        end else if (r < 70) begin
            c.rho = $urandom_range(16, 1);
            c.mx = rand_word(0); c.my = rand_word(0); c.en = rand_word(0);
        end else if (r < 78) begin
            c.rho = -$signed($urandom_range(1000));
            c.mx = rand_word(0); c.my = rand_word(0); c.en = rand_word(0);
        end else begin
            c.rho = rand_word($urandom_range(4));
            c.mx = rand_word($urandom_range(4));
            c.my = rand_word($urandom_range(4));
            c.en = rand_word($urandom_range(4));
        end
        return c;
    endfunction

    task automatic drain();
        while (cell_q.size() > 0 || flux_q.size() > 0 || s_valid) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic write_gamma(input logic [GAMMA_W-1:0] g);
        cfg_valid <= 1'b1;
        cfg_data <= g;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        gamma_reg = g;
        @(posedge aclk);
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle = idle;
        recv_stall = stall;
        repeat (n) cell_q.push_back(rand_cell());
        drain();
    endtask

    initial begin
        cell_t c;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset gamma, field extremes, zero and negative density
        c = '{32'sh10000, 32'sh10000, -32'sh20000, 32'sh50000}; cell_q.push_back(c);
        c = '{32'sh0, 32'sh10000, 32'sh10000, 32'sh10000}; cell_q.push_back(c);
        c = '{-32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000}; cell_q.push_back(c);
        c = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}; cell_q.push_back(c);
        c = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000}; cell_q.push_back(c);
        c = '{32'sh1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}; cell_q.push_back(c);
        c = '{32'sh1, 32'sh80000000, 32'sh1, 32'sh80000000}; cell_q.push_back(c);
        c = '{32'sh7fffffff, 32'sh0, 32'sh0, 32'sh0}; cell_q.push_back(c);
        c = '{32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff}; cell_q.push_back(c);
        c = '{32'sh00018000, -32'sh00030000, 32'sh00002000, 32'sh00100000}; cell_q.push_back(c);
        c = '{32'sh2, -32'sh1, 32'sh1, -32'sh7fffffff}; cell_q.push_back(c);
        drain();

        // gamma of exactly one: zero pressure
        write_gamma(18'd65536);
        c = '{32'sh20000, 32'sh30000, 32'sh10000, 32'sh80000}; cell_q.push_back(c);
        c = '{32'sh1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}; cell_q.push_back(c);
        drain();
        // gamma at the register's all-zero value (below one: negative gamma-1) and all-one value
        write_gamma(18'd0);
        c = '{32'sh10000, 32'sh10000, 32'sh10000, 32'sh7fffffff}; cell_q.push_back(c);
        drain();
        write_gamma(18'h3ffff);
        c = '{32'sh10000, 32'sh10000, 32'sh10000, 32'sh7fffffff}; cell_q.push_back(c);
        c = '{32'sh10000, 32'sh0, 32'sh0, 32'sh80000000}; cell_q.push_back(c);
        drain();

        // random phases across gamma settings
        write_gamma(18'd65537);
        run_phase(100, 0, 0);
        write_gamma(18'd196608);
        run_phase(90, 71, 0);
        write_gamma(18'd32768);
        run_phase(90, 0, 71);
        write_gamma(GAMMA_RST);
        run_phase(90, 33, 33);

        // long receiver hold-off with the sender pushing: pipeline fills and stalls input
        write_gamma(GAMMA_W'($urandom_range(196608, 65537)));
        send_idle = 0;
        recv_stall = 0;
        hold_off = 3 * LATENCY;
        run_phase(100, 0, 0);
        write_gamma(GAMMA_W'($urandom));
        run_phase(80, 33, 33);

        $display("%0d results checked over several gamma settings, %0d with bad density,",
                 results_seen, n_bad);
        $display("%0d with saturated pressure; idle, stall and back-pressure phases run", n_sat);
        if (mismatches == 0 && flux_q.size() == 0) begin
            $display("euler_2d_flux_kernel regression: pass");
        end else begin
            $display("%0d mismatches, %0d items outstanding", mismatches, flux_q.size());
            $display("euler_2d_flux_kernel regression: fail");
        end
        $finish;
    end

endmodule
